>>> hdl/cmc_pkg.sv
// shared types, constants and helpers of the compliance mode controller
package cmc_pkg;

  localparam int MOTORS = 8;
  localparam int MOT_IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int MOT_CW = $clog2(MOTORS + 1);

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 32;
  localparam int MOTOR_W     = 5;
  localparam int POS_W       = 16;
  localparam int TIME_W      = 32;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [POS_W-1:0] STABLE_LIMIT = 16'd100;
  localparam logic [POS_W-1:0] HALF_TURN    = 16'd18000;
  localparam logic [POS_W:0]   POS_MAX      = 17'd36000;

  localparam logic [7:0] CLASS_OBSTACLE  = 8'd1;
  localparam logic [7:0] CLASS_PUSH      = 8'd2;
  localparam logic [7:0] CLASS_COMPLIANT = 8'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PULLBACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFR     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd3;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_OBSTACLE  = 2'd1,
    MODE_PUSH      = 2'd2,
    MODE_COMPLIANT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_TICK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } cmc_state_t;

  typedef struct packed {
    logic [15:0] pullback;
    logic [7:0]  conf_min;
    logic [15:0] refr_ms;
    logic [15:0] hold_ms;
  } cfg_t;

  // mode machine context, updated once per tick
  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] switch_time;
    logic              refr_act;
    logic [TIME_W-1:0] refr_start;
    logic              trk;
    logic [TIME_W-1:0] trk_start;
    logic              bright;
  } ctx_t;

  function automatic mode_t class_to_mode(input logic [7:0] cls);
    mode_t m;
    case (cls)
      CLASS_OBSTACLE:  m = MODE_OBSTACLE;
      CLASS_PUSH:      m = MODE_PUSH;
      CLASS_COMPLIANT: m = MODE_COMPLIANT;
      default:         m = MODE_NORMAL;
    endcase
    return m;
  endfunction

endpackage

>>> hdl/compliance_mode_controller.sv
// compliance mode controller top level
// A sample without tlast is stored and gives no command. A sample with tlast starts a
// tick: the position memories are swept one motor a cycle to test stability and roll
// current into previous positions, the mode machine updates in ST_TICK, then one
// command per motor leaves in motor order by a memory read, then a load of the output
// register, which waits while the previous command is stalled on the output side.
// The sweep length comes from the single read port of the position memories, the
// command phase from the read then load step per motor. in_tready stays low from the
// last sample until the last command is loaded.
module compliance_mode_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // motor_index, position_now, goal_request, class_code, confidence, time_ms
  input  logic [cmc_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_motor, goal_command, torque_on, mode_code, led_bright
  output logic [cmc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [cmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cmc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cmc_pkg::*;

  logic [MOTOR_W-1:0] in_motor;
  logic [POS_W-1:0]   in_pos;
  logic [POS_W-1:0]   in_goal;
  logic [7:0]         in_class;
  logic [7:0]         in_conf;
  logic [TIME_W-1:0]  in_time;

  assign in_motor = in_tdata[4:0];
  assign in_pos   = in_tdata[20:5];
  assign in_goal  = in_tdata[36:21];
  assign in_class = in_tdata[44:37];
  assign in_conf  = in_tdata[52:45];
  assign in_time  = in_tdata[84:53];

  cmc_state_t         state_r, state_nxt;
  logic [MOT_CW-1:0]  cnt_r, cnt_nxt;
  logic [MOT_IW-1:0]  rd_addr;
  logic               in_acc;
  logic               out_acc;
  logic               cnt_last;
  logic               emit_load;
  logic               in_store;

  logic               scan_vld_r;
  logic [MOT_IW-1:0]  scan_idx_r;
  logic               moved_r;
  logic               hist_r;

  cfg_t               cfg_r;
  ctx_t               ctx_r, ctx_nxt;
  logic [TIME_W-1:0]  t_r;
  logic [7:0]         cls_r;
  logic [7:0]         conf_r;

  // per motor {goal_request, position_now}, and previous positions
  logic [2*POS_W-1:0] mem_a [MOTORS];
  logic [POS_W-1:0]   mem_p [MOTORS];
  logic [2*POS_W-1:0] rd_a_r;
  logic [POS_W-1:0]   rd_p_r;

  logic               out_valid_r;
  logic               out_last_r;
  logic [MOTOR_W-1:0] out_motor_r;
  logic [POS_W-1:0]   out_goal_r;
  logic               out_torque_r;
  mode_t              out_mode_r;
  logic               out_bright_r;

  logic [POS_W-1:0]   cur_pos;
  logic [POS_W-1:0]   cur_goal;
  logic [POS_W:0]     goal_raw;
  logic [POS_W-1:0]   goal_cmd;
  logic [POS_W-1:0]   pos_delta;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;
  assign cnt_last  = (cnt_r == MOT_CW'(MOTORS - 1));
  assign rd_addr   = cnt_r[MOT_IW-1:0];
  assign in_store  = in_acc && ({1'b0, in_motor} < (MOTOR_W + 1)'(MOTORS));

  always_ff @(posedge clk) begin
    if (in_store) begin
      mem_a[in_motor[MOT_IW-1:0]] <= {in_goal, in_pos};
    end
    rd_a_r <= mem_a[rd_addr];
  end

  // previous entry written behind the read pointer, never the same motor
  always_ff @(posedge clk) begin
    if (scan_vld_r) begin
      mem_p[scan_idx_r] <= rd_a_r[POS_W-1:0];
    end
    rd_p_r <= mem_p[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pullback <= 16'd500;
      cfg_r.conf_min <= 8'd128;
      cfg_r.refr_ms  <= 16'd1000;
      cfg_r.hold_ms  <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PULLBACK: cfg_r.pullback <= cfg_data;
        CFG_CONF_MIN: cfg_r.conf_min <= cfg_data[7:0];
        CFG_REFR:     cfg_r.refr_ms  <= cfg_data;
        CFG_HOLD:     cfg_r.hold_ms  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    emit_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tlast) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_last) begin
          state_nxt = ST_SCAN_END;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCAN_END: state_nxt = ST_TICK;
      ST_TICK:     state_nxt = ST_EMIT_RD;
      ST_EMIT_RD: begin
        if (!out_valid_r || out_acc) begin
          state_nxt = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        emit_load = 1'b1;
        if (cnt_last) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          state_nxt = ST_EMIT_RD;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign pos_delta = (rd_a_r[POS_W-1:0] >= rd_p_r) ? (rd_a_r[POS_W-1:0] - rd_p_r)
                                                   : (rd_p_r - rd_a_r[POS_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
      moved_r    <= 1'b0;
      hist_r     <= 1'b0;
    end else begin
      scan_vld_r <= (state_r == ST_SCAN);
      if (in_acc && in_tlast) begin
        moved_r <= 1'b0;
      end else if (scan_vld_r && (pos_delta > STABLE_LIMIT)) begin
        moved_r <= 1'b1;
      end
      if (state_r == ST_TICK) begin
        hist_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= rd_addr;
    if (in_acc && in_tlast) begin
      t_r    <= in_time;
      cls_r  <= in_class;
      conf_r <= in_conf;
    end
  end

  cmc_tick u_tick (
    .ctx     (ctx_r),
    .cfg     (cfg_r),
    .t       (t_r),
    .cls     (cls_r),
    .conf    (conf_r),
    .moved   (moved_r || !hist_r),
    .ctx_nxt (ctx_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '{mode: MODE_NORMAL, default: '0};
    end else if (state_r == ST_TICK) begin
      ctx_r <= ctx_nxt;
    end
  end

  assign cur_pos  = rd_a_r[POS_W-1:0];
  assign cur_goal = rd_a_r[2*POS_W-1:POS_W];

  always_comb begin
    case (ctx_r.mode)
      MODE_OBSTACLE: goal_raw = {1'b0, cur_pos};
      MODE_PUSH: begin
        if (cur_goal > HALF_TURN) begin
          goal_raw = (cur_pos > cfg_r.pullback) ? {1'b0, cur_pos - cfg_r.pullback} : '0;
        end else begin
          goal_raw = {1'b0, cur_pos} + {1'b0, cfg_r.pullback};
        end
      end
      default: goal_raw = '0;
    endcase
    goal_cmd = (goal_raw > POS_MAX) ? POS_MAX[POS_W-1:0] : goal_raw[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_motor_r  <= MOTOR_W'(cnt_r);
      out_goal_r   <= goal_cmd;
      out_torque_r <= (ctx_r.mode != MODE_COMPLIANT);
      out_mode_r   <= ctx_r.mode;
      out_bright_r <= ctx_r.bright;
      out_last_r   <= cnt_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_bright_r, out_mode_r, out_torque_r, out_goal_r, out_motor_r};

endmodule

>>> hdl/cmc_tick.sv
// mode machine update for one control tick
module cmc_tick (
  input  cmc_pkg::ctx_t                ctx,
  input  cmc_pkg::cfg_t                cfg,
  input  logic [cmc_pkg::TIME_W-1:0]   t,
  input  logic [7:0]                   cls,
  input  logic [7:0]                   conf,
  input  logic                         moved,
  output cmc_pkg::ctx_t                ctx_nxt
);
  import cmc_pkg::*;

  logic [TIME_W-1:0] trk_age;
  logic [TIME_W-1:0] refr_age;
  logic [TIME_W-1:0] dwell_age;
  logic [TIME_W-1:0] sw_eff;
  logic              trk_now;
  logic [TIME_W-1:0] trk_start_now;
  logic              refr_block;
  logic              changed;
  mode_t             start;
  mode_t             next;
  ctx_t              c;

  always_comb begin
    start         = ctx.mode;
    trk_now       = ctx.trk;
    trk_start_now = ctx.trk_start;
    if (!moved) begin
      if (!ctx.trk) begin
        trk_now       = 1'b1;
        trk_start_now = t;
      end
    end else begin
      trk_now = 1'b0;
    end

    c           = ctx;
    c.trk       = trk_now;
    c.trk_start = trk_start_now;

    trk_age    = t - trk_start_now;
    refr_age   = t - ctx.refr_start;
    refr_block = ctx.refr_act && (refr_age < {16'd0, cfg.refr_ms});
    next       = (conf >= cfg.conf_min) ? class_to_mode(cls) : start;
    changed    = 1'b0;

    if (start == MODE_COMPLIANT) begin
      if (trk_now && (trk_age >= {16'd0, cfg.hold_ms})) begin
        c.mode        = MODE_NORMAL;
        c.switch_time = t;
        c.trk         = 1'b0;
      end
    end else if (!refr_block) begin
      c.refr_act = 1'b0;
      if (next != start) begin
        changed       = 1'b1;
        c.mode        = next;
        c.switch_time = t;
        if (next != MODE_NORMAL) begin
          c.refr_act   = 1'b1;
          c.refr_start = t;
        end
        if (next == MODE_COMPLIANT) begin
          c.trk = 1'b0;
        end
      end
    end

    // dwell timeout out of push or obstacle, against the updated switch time
    sw_eff    = changed ? t : ctx.switch_time;
    dwell_age = t - sw_eff;
    if ((start == MODE_PUSH || start == MODE_OBSTACLE) &&
        (dwell_age >= {16'd0, cfg.refr_ms})) begin
      c.mode        = MODE_NORMAL;
      c.switch_time = t;
    end

    if (c.mode != MODE_NORMAL) begin
      c.bright = 1'b1;
    end
    ctx_nxt = c;
  end

endmodule

>>> hdl/cmc_checker.sv
// port level checks of the compliance mode controller, bound to the top level
module cmc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              in_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [cmc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              out_tlast
);
  import cmc_pkg::*;

  // a stalled command holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled command changed");

  // a sample that does not close the tick never starts commands
  a_no_cmd_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> !$rose(out_tvalid))
    else $error("command started by a non-final sample");

  // the block is busy right after the final sample of a tick
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("item taken while a tick is in work");

  // compliant commands have torque off
  a_compliant_torque: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[23:22] == MODE_COMPLIANT) |-> !out_tdata[21])
    else $error("torque on in compliant mode");

  // the last command of a tick is for the last motor
  a_last_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[4:0] == MOTOR_W'(MOTORS - 1))
    else $error("last flag on wrong motor");

endmodule

bind compliance_mode_controller cmc_checker u_cmc_checker (.*);

>>> verif/compliance_mode_controller_tb.sv
// self-checking testbench of the compliance mode controller, with its own mode machine model
module compliance_mode_controller_tb;
  import cmc_pkg::*;

  localparam logic [7:0] CLASS_NONE   = 8'd0;
  localparam logic [7:0] CLASS_MAXVAL = 8'hFF;
  localparam int         DRAIN_CYCLES = 3 * MOTORS + 12;

  typedef struct {
    logic [4:0]  motor;
    logic [15:0] pos;
    logic [15:0] goal;
    logic [7:0]  cls;
    logic [7:0]  conf;
    logic [31:0] t;
    logic        last;
  } sample_t;

  typedef struct {
    logic [4:0]  motor;
    logic [15:0] goal;
    logic        torque;
    logic [1:0]  md;
    logic        bright;
    logic        last;
  } cmd_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  compliance_mode_controller DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // model configuration and state
  logic [15:0] pullback = 16'd500;
  logic [7:0]  conf_min = 8'd128;
  logic [15:0] refr_ms  = 16'd1000;
  logic [15:0] hold_ms  = 16'd2000;

  mode_t       mode_q = MODE_NORMAL;
  logic [31:0] sw_time = '0;
  bit          refr_act = 1'b0;
  logic [31:0] refr_start = '0;
  bit          trk = 1'b0;
  logic [31:0] trk_start = '0;
  bit          hist_valid = 1'b0;
  bit          bright = 1'b0;
  logic [15:0] cur_pos [MOTORS];
  logic [15:0] prev_pos [MOTORS];
  logic [15:0] goal_req [MOTORS];

  sample_t     sample_queue [$];
  cmd_t        expected_cmds [$];
  int          err_count = 0;
  int          cmds_seen = 0;
  bit          idle_on = 1'b1;
  bit          in_taken = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;

  // stimulus bookkeeping
  int          pos_track [MOTORS];
  logic [31:0] now_ms = '0;
  int          phase_items = 0;

  function automatic logic [31:0] elapsed(input logic [31:0] t, input logic [31:0] since);
    return t - since;
  endfunction

  function automatic mode_t mode_of_class(input logic [7:0] cls);
    if (cls == CLASS_OBSTACLE) return MODE_OBSTACLE;
    if (cls == CLASS_PUSH) return MODE_PUSH;
    if (cls == CLASS_COMPLIANT) return MODE_COMPLIANT;
    return MODE_NORMAL;
  endfunction

  function automatic logic [15:0] goal_of(input int m);
    logic [31:0] p;
    logic [31:0] g;
    p = cur_pos[m];
    if (mode_q == MODE_OBSTACLE) begin
      g = p;
    end else if (mode_q == MODE_PUSH) begin
      if (goal_req[m] > HALF_TURN) g = (p > pullback) ? p - pullback : 32'd0;
      else g = p + pullback;
    end else begin
      return 16'd0;
    end
    if (g > POS_MAX) g = POS_MAX;
    return g[15:0];
  endfunction

  task automatic run_tick(input logic [31:0] t, input logic [7:0] cls, input logic [7:0] conf);
    mode_t       start_md;
    mode_t       nxt;
    bit          moved;
    logic [15:0] dp;
    start_md = mode_q;
    moved = !hist_valid;
    for (int i = 0; i < MOTORS; i++) begin
      dp = (cur_pos[i] > prev_pos[i]) ? cur_pos[i] - prev_pos[i] : prev_pos[i] - cur_pos[i];
      if (dp > STABLE_LIMIT) moved = 1'b1;
    end
    if (!moved) begin
      if (!trk) begin
        trk = 1'b1;
        trk_start = t;
      end
    end else begin
      trk = 1'b0;
    end
    if (start_md == MODE_COMPLIANT) begin
      // classifier ignored, leave only after a long enough still period
      if (trk && elapsed(t, trk_start) >= hold_ms) begin
        mode_q = MODE_NORMAL;
        sw_time = t;
        trk = 1'b0;
      end
    end else begin
      if (!(refr_act && elapsed(t, refr_start) < refr_ms)) begin
        nxt = start_md;
        refr_act = 1'b0;
        if (conf >= conf_min) nxt = mode_of_class(cls);
        if (nxt != start_md) begin
          mode_q = nxt;
          sw_time = t;
          if (nxt != MODE_NORMAL) begin
            refr_act = 1'b1;
            refr_start = t;
          end
          if (nxt == MODE_COMPLIANT) trk = 1'b0;
        end
      end
      // obstacle and push fall back to normal after the dwell time
      if ((start_md == MODE_PUSH || start_md == MODE_OBSTACLE) &&
          elapsed(t, sw_time) >= refr_ms) begin
        mode_q = MODE_NORMAL;
        sw_time = t;
      end
    end
    for (int i = 0; i < MOTORS; i++) prev_pos[i] = cur_pos[i];
    hist_valid = 1'b1;
    if (mode_q != MODE_NORMAL) bright = 1'b1;
  endtask

  task automatic take_sample(input logic [IN_TDATA_W-1:0] d, input logic lst);
    logic [4:0] idx;
    cmd_t       c;
    idx = d[4:0];
    if (idx < MOTORS) begin
      cur_pos[idx[MOT_IW-1:0]] = d[20:5];
      goal_req[idx[MOT_IW-1:0]] = d[36:21];
    end
    if (lst) begin
      run_tick(d[84:53], d[44:37], d[52:45]);
      for (int i = 0; i < MOTORS; i++) begin
        c.motor = i[4:0];
        c.goal = goal_of(i);
        c.torque = (mode_q != MODE_COMPLIANT);
        c.md = mode_q;
        c.bright = bright;
        c.last = (i == MOTORS - 1);
        expected_cmds.push_back(c);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got)
      report_mismatch($sformatf("command %0d %s expected %0d got %0d",
                                cmds_seen, name, want, got));
  endtask

  // driver: accepted items go through the model at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      take_sample(in_tdata, in_tlast);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    sample_t s;
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (sample_queue.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(1, 6) - 1;
        in_tvalid <= 1'b0;
      end else begin
        s = sample_queue.pop_front();
        in_tdata <= {3'b000, s.t, s.conf, s.cls, s.goal, s.pos, s.motor};
        in_tlast <= s.last;
        in_tvalid <= 1'b1;
      end
    end
  end

  // monitor: compare every command with the oldest one expected
  always @(posedge clk) begin
    cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected command for motor %0d", out_tdata[4:0]));
      end else begin
        want = expected_cmds.pop_front();
        check_field("motor", want.motor, out_tdata[4:0]);
        check_field("goal", want.goal, out_tdata[20:5]);
        check_field("torque", want.torque, out_tdata[21]);
        check_field("mode", want.md, out_tdata[23:22]);
        check_field("bright", want.bright, out_tdata[24]);
        check_field("last", want.last, out_tlast);
      end
      cmds_seen++;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall = $urandom_range(1, 6) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic add_sample(input int motor, input int pos, input int goal,
                            input logic [7:0] cls, input logic [7:0] conf,
                            input logic [31:0] t, input logic last);
    sample_t s;
    s.motor = motor[4:0];
    s.pos = pos[15:0];
    s.goal = goal[15:0];
    s.cls = cls;
    s.conf = conf;
    s.t = t;
    s.last = last;
    sample_queue.push_back(s);
    if (motor < MOTORS) begin
      pos_track[motor] = pos;
      phase_items++;
    end
  endtask

  function automatic int next_pos(input int m, input bit still);
    int p;
    if (still) p = pos_track[m] + int'($urandom_range(0, 200)) - 100;
    else if ($urandom_range(0, 1) == 0)
      p = pos_track[m] + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(101, 2000));
    else p = $urandom_range(0, 36000);
    if (p < 0) p = 0;
    if (p > 36000) p = 36000;
    return p;
  endfunction

  function automatic int rand_goal();
    case ($urandom_range(0, 5))
      0: return 18000;
      1: return 18001;
      default: return $urandom_range(0, 36000);
    endcase
  endfunction

  function automatic logic [7:0] rand_conf();
    case ($urandom_range(0, 4))
      0: return conf_min;
      1: return (conf_min == 0) ? 8'd0 : conf_min - 8'd1;
      2: return CLASS_MAXVAL;
      3: return 8'd0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic advance_time();
    int step;
    case ($urandom_range(0, 9))
      0: step = 0;
      1, 2: step = $urandom_range(0, refr_ms / 2 + 1);
      3: step = int'(refr_ms) + int'($urandom_range(0, 2)) - 1;
      4: step = int'(hold_ms) + int'($urandom_range(0, 2)) - 1;
      5: step = $urandom_range(0, 131071);
      6: step = $urandom_range(1, 50);
      default: step = $urandom_range(0, refr_ms + 20);
    endcase
    if (step < 0) step = 0;
    // now and then jump close to the wrap of the millisecond counter
    if ($urandom_range(0, 39) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 4000);
    else now_ms = now_ms + step;
  endtask

  task automatic gen_tick();
    bit         still;
    int         style;
    int         m;
    logic [7:0] cls;
    still = ($urandom_range(0, 9) < 6);
    style = $urandom_range(0, 9);
    if (style < 6) begin
      // every motor in order, now and then with a sample for a motor that does not exist between
      for (int i = 0; i < MOTORS - 1; i++) begin
        if ($urandom_range(0, 15) == 0)
          add_sample($urandom_range(MOTORS, 31), $urandom_range(0, 36000), rand_goal(),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), now_ms, 1'b0);
        add_sample(i, next_pos(i, still), rand_goal(), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), now_ms, 1'b0);
      end
      m = MOTORS - 1;
    end else if (style < 8) begin
      // partial tick, some motors missing or repeated
      repeat ($urandom_range(0, 4)) begin
        m = $urandom_range(0, MOTORS - 1);
        add_sample(m, next_pos(m, still), rand_goal(), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), now_ms, 1'b0);
      end
      m = $urandom_range(0, MOTORS - 1);
    end else begin
      // samples for motors that do not exist
      repeat ($urandom_range(1, 3))
        add_sample($urandom_range(MOTORS, 31), $urandom_range(0, 36000), rand_goal(),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), now_ms, 1'b0);
      m = $urandom_range(0, 1) ? int'($urandom_range(MOTORS, 31)) : MOTORS - 1;
    end
    advance_time();
    cls = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
    if (m < MOTORS)
      add_sample(m, next_pos(m, still), rand_goal(), cls, rand_conf(), now_ms, 1'b1);
    else
      add_sample(m, $urandom_range(0, 36000), rand_goal(), cls, rand_conf(), now_ms, 1'b1);
  endtask

  task automatic random_ticks(input int n);
    phase_items = 0;
    while (phase_items < n) gen_tick();
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_tvalid || expected_cmds.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_PULLBACK: pullback = val;
      CFG_CONF_MIN: conf_min = val[7:0];
      CFG_REFR:     refr_ms = val;
      default:      hold_ms = val;
    endcase
  endtask

  task automatic write_all(input int pb, input int cm, input int rf, input int hd);
    write_reg(CFG_PULLBACK, pb[15:0]);
    write_reg(CFG_CONF_MIN, cm[15:0]);
    write_reg(CFG_REFR, rf[15:0]);
    write_reg(CFG_HOLD, hd[15:0]);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_all(500, 128, 1000, 2000);
    // first tick writes every motor: push at the exact threshold, saturation at both ends
    add_sample(0, 0, 18001, CLASS_NONE, 8'd0, 32'd5, 1'b0);
    add_sample(1, 36000, 18000, CLASS_NONE, 8'd0, 32'd5, 1'b0);
    add_sample(2, 100, 0, CLASS_NONE, 8'd0, 32'd5, 1'b0);
    add_sample(3, 35900, 36000, CLASS_NONE, 8'd0, 32'd5, 1'b0);
    add_sample(4, 18000, 18001, CLASS_NONE, 8'd0, 32'd5, 1'b0);
    add_sample(5, 500, 18000, CLASS_NONE, 8'd0, 32'd5, 1'b0);
    add_sample(6, 35501, 36000, CLASS_NONE, 8'd0, 32'd5, 1'b0);
    add_sample(7, 12345, 0, CLASS_PUSH, 8'd128, 32'd5, 1'b1);
    // inside refractory, then just after it, then the dwell back to normal
    add_sample(7, 12345, 0, CLASS_OBSTACLE, CLASS_MAXVAL, 32'd500, 1'b1);
    add_sample(7, 12345, 0, CLASS_OBSTACLE, CLASS_MAXVAL, 32'd1005, 1'b1);
    add_sample(7, 12345, 0, CLASS_NONE, 8'd0, 32'd2005, 1'b1);
    // compliant, classifier ignored, stable hold one short then exact
    add_sample(7, 12345, 0, CLASS_COMPLIANT, 8'd200, 32'd2007, 1'b1);
    add_sample(7, 12345, 0, CLASS_NONE, CLASS_MAXVAL, 32'd2500, 1'b1);
    add_sample(7, 12345, 0, CLASS_NONE, CLASS_MAXVAL, 32'd4499, 1'b1);
    add_sample(7, 12345, 0, CLASS_NONE, CLASS_MAXVAL, 32'd4500, 1'b1);
    // one motor moves by 101, then by exactly 100
    add_sample(2, 201, 0, CLASS_NONE, 8'd0, 32'd4600, 1'b0);
    add_sample(7, 12345, 0, CLASS_COMPLIANT, CLASS_MAXVAL, 32'd4600, 1'b1);
    add_sample(2, 301, 0, CLASS_NONE, 8'd0, 32'd4700, 1'b0);
    add_sample(7, 12345, 0, CLASS_NONE, 8'd0, 32'd4700, 1'b1);
    add_sample(7, 12345, 0, CLASS_MAXVAL, CLASS_MAXVAL, 32'd6700, 1'b1);
    // tick carried by a motor that does not exist, and an ignored sample
    add_sample(31, 777, 777, CLASS_OBSTACLE, CLASS_MAXVAL, 32'd7000, 1'b1);
    add_sample(8, 30000, 30000, CLASS_NONE, 8'd0, 32'd7000, 1'b0);
    // time wraps
    add_sample(7, 12345, 0, CLASS_NONE, CLASS_MAXVAL, 32'hFFFF_FFF0, 1'b1);
    add_sample(7, 12345, 0, CLASS_PUSH, CLASS_MAXVAL, 32'h0000_0100, 1'b1);
    add_sample(7, 12345, 0, CLASS_NONE, 8'd0, 32'h0000_0500, 1'b1);
    now_ms = 32'h0000_0500;
    random_ticks(50);
    wait_idle();

    write_all(36000, 0, 0, 0);
    random_ticks(50);
    wait_idle();

    write_all(0, 255, 65535, 65535);
    random_ticks(50);
    wait_idle();

    write_all($urandom_range(0, 36000), $urandom_range(0, 255),
              $urandom_range(0, 3000), $urandom_range(0, 5000));
    random_ticks(30);
    wait_idle();

    // closing stretch runs at full rate on both sides
    idle_on = 1'b0;
    write_all(500, 128, 1000, 2000);
    random_ticks(30);
    wait_idle();

    if (expected_cmds.size() != 0)
      report_mismatch($sformatf("%0d expected commands never arrived", expected_cmds.size()));
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
